FILE: hdl/bmp_pixel_data_decoder_macros.svh
// Assertion macros for the bitmap pixel decoder sequencer module.
// Expects signals named clock and reset in the including module.
`ifndef BMP_PIXEL_DATA_DECODER_MACROS_SVH
`define BMP_PIXEL_DATA_DECODER_MACROS_SVH

// Condition holds on every clock edge out of reset.
`define BPD_ASSERT_ALWAYS(label, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("bmp decoder invariant violated");

// Consequent holds in the same cycle as the antecedent.
`define BPD_ASSERT_IMPLY(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("bmp decoder implication violated");

`endif

FILE: hdl/bmp_pd_pkg.sv
// Shared types and codes for the bitmap pixel data decoder.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package bmp_pd_pkg;

   localparam logic OP_PALETTE = 1'b0;
   localparam logic OP_PIXEL   = 1'b1;

   localparam logic [2:0] DEPTH_1BPP  = 3'd0;
   localparam logic [2:0] DEPTH_4BPP  = 3'd1;
   localparam logic [2:0] DEPTH_8BPP  = 3'd2;
   localparam logic [2:0] DEPTH_24BPP = 3'd3;
   localparam logic [2:0] DEPTH_32BPP = 3'd4;

   localparam logic [2:0] CSR_DEPTH_MODE   = 3'd0;
   localparam logic [2:0] CSR_IMAGE_WIDTH  = 3'd1;
   localparam logic [2:0] CSR_IMAGE_HEIGHT = 3'd2;
   localparam logic [2:0] CSR_BOTTOM_UP    = 3'd3;
   localparam logic [2:0] CSR_KEEP_ALPHA   = 3'd4;

   localparam logic [7:0] ALPHA_OPAQUE = 8'hff;

   typedef struct packed {
      logic        operation;
      logic [7:0]  data_byte;
      logic [7:0]  palette_index;
      logic [23:0] palette_word;
   } req_type;

   typedef struct packed {
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [7:0]  alpha;
      logic [11:0] column;
      logic [11:0] row;
      logic        last_of_byte;
      logic        frame_done;
   } rsp_type;

   typedef struct packed {
      logic [2:0]  depth_mode;
      logic [12:0] image_width;
      logic [12:0] image_height;
      logic        bottom_up;
      logic        keep_alpha;
   } cfg_type;

   // One pixel on its way to the palette lookup stage.
   typedef struct packed {
      logic        direct;
      logic [7:0]  index;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [7:0]  alpha;
      logic [11:0] column;
      logic [11:0] row;
      logic        last_of_byte;
      logic        frame_done;
   } pix_type;

   typedef struct packed {
      logic        we;
      logic [7:0]  index;
      logic [23:0] word;
   } pal_wr_type;

endpackage

FILE: hdl/bmp_pd_sequencer.sv
// Input holding register and frame position tracking for the bitmap decoder.
// Splits each byte into pixels, one per cycle if pix_ready; uses bmp_pd_pkg.
`timescale 1ns / 1ps

module bmp_pd_sequencer #(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic                   clock,
   input  logic                   reset,
   input  bmp_pd_pkg::cfg_type    cfg,
   input  logic                   restart,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  bmp_pd_pkg::req_type    req_data,
   output logic                   pix_valid,
   output bmp_pd_pkg::pix_type    pix,
   input  logic                   pix_ready,
   output bmp_pd_pkg::pal_wr_type pal_wr
);
   import bmp_pd_pkg::*;
`include "bmp_pixel_data_decoder_macros.svh"

   localparam int CW = $clog2(MAX_WIDTH + 1);
   localparam int LW = $clog2(MAX_HEIGHT + 1);

   function automatic logic [1:0] row_pad(logic [2:0] m, logic [4:0] w5);
      logic [5:0] s8;
      logic [3:0] s2;
      logic [1:0] bpl;
      s8 = 6'(w5) + 6'd7;
      s2 = 4'(w5[2:0]) + 4'd1;
      unique case (m)
         DEPTH_1BPP:  bpl = s8[4:3];
         DEPTH_4BPP:  bpl = s2[2:1];
         DEPTH_8BPP:  bpl = w5[1:0];
         DEPTH_24BPP: bpl = w5[1:0] + {w5[0], 1'b0};
         default:     bpl = 2'd0;
      endcase
      return 2'd0 - bpl;
   endfunction

   req_type        hold_ff;
   logic           hold_valid_ff;
   logic [2:0]     sub_ff, sub_in;
   logic [CW-1:0]  col_ff, col_in, col_p1, width;
   logic [LW-1:0]  line_ff, line_in, line_p1, height, row_pos;
   logic [1:0]     pad_ff, pad_in;
   logic [23:0]    gather_ff, gather_in;
   logic [1:0]     cnt_ff, cnt_in;
   logic           fin_ff, fin_in;
   logic [2:0]     mode;
   logic           wrap, last_line, last_sub, done, emit;
   logic [7:0]     byte_v;

   always_comb begin
      if (cfg.image_width == '0) width = CW'(1);
      else if (32'(cfg.image_width) > MAX_WIDTH) width = CW'(MAX_WIDTH);
      else width = CW'(cfg.image_width);
      if (cfg.image_height == '0) height = LW'(1);
      else if (32'(cfg.image_height) > MAX_HEIGHT) height = LW'(MAX_HEIGHT);
      else height = LW'(cfg.image_height);
      mode = (cfg.depth_mode > DEPTH_32BPP) ? DEPTH_32BPP : cfg.depth_mode;
   end

   assign byte_v    = hold_ff.data_byte;
   assign col_p1    = col_ff + CW'(1);
   assign line_p1   = line_ff + LW'(1);
   assign wrap      = col_p1 >= width;
   assign last_line = line_p1 >= height;
   assign row_pos   = cfg.bottom_up ? (height - LW'(1) - line_ff) : line_ff;

   always_comb begin
      unique case (mode)
         DEPTH_1BPP: last_sub = sub_ff == 3'd7;
         DEPTH_4BPP: last_sub = sub_ff[0];
         default:    last_sub = 1'b1;
      endcase
   end

   always_comb begin
      col_in    = col_ff;
      line_in   = line_ff;
      pad_in    = pad_ff;
      gather_in = gather_ff;
      cnt_in    = cnt_ff;
      fin_in    = fin_ff;
      done      = 1'b0;
      emit      = 1'b0;
      pix              = '0;
      pix.alpha        = ALPHA_OPAQUE;
      pix.column       = 12'(col_ff);
      pix.row          = 12'(row_pos);
      pal_wr.we        = hold_valid_ff && (hold_ff.operation == OP_PALETTE);
      pal_wr.index     = hold_ff.palette_index;
      pal_wr.word      = hold_ff.palette_word;

      if (hold_valid_ff) begin
         priority if (hold_ff.operation == OP_PALETTE) begin
            done = 1'b1;
         end else if (fin_ff) begin
            done = 1'b1;
         end else if (pad_ff != 2'd0) begin
            pad_in = pad_ff - 2'd1;
            done   = 1'b1;
         end else if (mode == DEPTH_24BPP || mode == DEPTH_32BPP) begin
            if (cnt_ff < ((mode == DEPTH_24BPP) ? 2'd2 : 2'd3)) begin
               gather_in[{cnt_ff, 3'b000} +: 8] = byte_v;
               cnt_in = cnt_ff + 2'd1;
               done   = 1'b1;
            end else if (pix_ready) begin
               emit       = 1'b1;
               done       = 1'b1;
               pix.direct = 1'b1;
               pix.green  = gather_ff[15:8];
               pix.blue   = gather_ff[7:0];
               if (mode == DEPTH_24BPP) begin
                  pix.red = byte_v;
               end else begin
                  pix.red   = gather_ff[23:16];
                  pix.alpha = cfg.keep_alpha ? byte_v : ALPHA_OPAQUE;
               end
               gather_in = '0;
               cnt_in    = 2'd0;
            end
         end else if (pix_ready) begin
            emit = 1'b1;
            done = last_sub || wrap;
            unique case (mode)
               DEPTH_1BPP: pix.index = {7'd0, byte_v[3'd7 - sub_ff]};
               DEPTH_4BPP: pix.index = {4'd0, sub_ff[0] ? byte_v[3:0] : byte_v[7:4]};
               default:    pix.index = byte_v;
            endcase
         end

         if (emit) begin
            pix.last_of_byte = done;
            if (wrap) begin
               col_in  = '0;
               line_in = line_p1;
               if (last_line) begin
                  fin_in         = 1'b1;
                  pad_in         = 2'd0;
                  pix.frame_done = 1'b1;
               end else begin
                  pad_in = row_pad(mode, 5'(width));
               end
            end else begin
               col_in = col_p1;
            end
         end
      end
   end

   assign pix_valid = emit;
   assign req_stall = hold_valid_ff && !done;
   assign sub_in    = done ? 3'd0 : (emit ? sub_ff + 3'd1 : sub_ff);

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         col_ff    <= '0;
         line_ff   <= '0;
         pad_ff    <= 2'd0;
         gather_ff <= '0;
         cnt_ff    <= 2'd0;
         fin_ff    <= 1'b0;
      end else begin
         col_ff    <= col_in;
         line_ff   <= line_in;
         pad_ff    <= pad_in;
         gather_ff <= gather_in;
         cnt_ff    <= cnt_in;
         fin_ff    <= fin_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         sub_ff        <= 3'd0;
      end else begin
         if (!req_stall) hold_valid_ff <= req_valid;
         sub_ff <= sub_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) hold_ff <= req_data;
   end

   `BPD_ASSERT_ALWAYS(a_col_in_row, col_ff < width)
   `BPD_ASSERT_IMPLY(a_pad_not_finished, pad_ff != 2'd0, !fin_ff)
   `BPD_ASSERT_IMPLY(a_emit_when_ready, pix_valid, pix_ready)
   `BPD_ASSERT_IMPLY(a_frame_end_frees, pix_valid && pix.frame_done, !req_stall)

endmodule

FILE: hdl/bmp_pd_lookup.sv
// Palette store and pixel output register for the bitmap decoder.
// Registered palette read feeds the result channel; depends on bmp_pd_pkg.
`timescale 1ns / 1ps

module bmp_pd_lookup #(
   parameter int PALETTE_DEPTH = 256
) (
   input  logic                   clock,
   input  logic                   reset,
   input  bmp_pd_pkg::pal_wr_type pal_wr,
   input  logic                   pix_valid,
   input  bmp_pd_pkg::pix_type    pix,
   output logic                   pix_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output bmp_pd_pkg::rsp_type    rsp_data
);
   import bmp_pd_pkg::*;

   localparam int AW = $clog2(PALETTE_DEPTH);

   logic [23:0] palette_ff [PALETTE_DEPTH];
   logic [23:0] rd_ff;
   pix_type     info_ff;
   logic        oob_ff;
   logic        valid_ff;

   assign pix_ready = !valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (pal_wr.we && ({1'b0, pal_wr.index} < 9'(PALETTE_DEPTH))) begin
         palette_ff[pal_wr.index[AW-1:0]] <= pal_wr.word;
      end
   end

   always_ff @(posedge clock) begin
      if (pix_valid && pix_ready) begin
         rd_ff   <= palette_ff[pix.index[AW-1:0]];
         info_ff <= pix;
         oob_ff  <= {1'b0, pix.index} >= 9'(PALETTE_DEPTH);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else if (pix_ready) valid_ff <= pix_valid;
   end

   always_comb begin
      rsp_data.column       = info_ff.column;
      rsp_data.row          = info_ff.row;
      rsp_data.last_of_byte = info_ff.last_of_byte;
      rsp_data.frame_done   = info_ff.frame_done;
      if (info_ff.direct) begin
         rsp_data.red   = info_ff.red;
         rsp_data.green = info_ff.green;
         rsp_data.blue  = info_ff.blue;
         rsp_data.alpha = info_ff.alpha;
      end else if (oob_ff) begin
         rsp_data.red   = 8'd0;
         rsp_data.green = 8'd0;
         rsp_data.blue  = 8'd0;
         rsp_data.alpha = ALPHA_OPAQUE;
      end else begin
         rsp_data.red   = rd_ff[23:16];
         rsp_data.green = rd_ff[15:8];
         rsp_data.blue  = rd_ff[7:0];
         rsp_data.alpha = ALPHA_OPAQUE;
      end
   end

   assign rsp_valid = valid_ff;

endmodule

FILE: hdl/bmp_pixel_data_decoder.sv
// Uncompressed bitmap pixel array decoder. Takes one request per transfer: a
// palette load or one byte of the pixel array. Palette loads, row padding bytes,
// and the first bytes of a 24/32bpp pixel each complete with no result. A byte
// yields one pixel for 8bpp and the last byte of a 24/32bpp pixel, up to 2 for
// 4bpp, up to 8 for 1bpp. The single palette read port issues one pixel per
// cycle while the result port is not stalled. Each pixel passes through the
// input holding register and the lookup output register. Palette entries read
// before being loaded return unspecified color; there is no clearing pass. Any
// write to a defined register index restarts the frame position. Depends on
// bmp_pd_pkg, bmp_pd_sequencer and bmp_pd_lookup.
`timescale 1ns / 1ps

module bmp_pixel_data_decoder #(
   parameter int MAX_WIDTH     = 4096,
   parameter int MAX_HEIGHT    = 4096,
   parameter int PALETTE_DEPTH = 256
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  bmp_pd_pkg::req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output bmp_pd_pkg::rsp_type rsp_data,
   input  logic                csr_we,
   input  logic [2:0]          csr_index,
   input  logic [12:0]         csr_wdata
);
   import bmp_pd_pkg::*;

   cfg_type    cfg_ff;
   logic       restart;
   logic       pix_valid;
   logic       pix_ready;
   pix_type    pix;
   pal_wr_type pal_wr;

   assign restart = csr_we && (csr_index <= CSR_KEEP_ALPHA);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{depth_mode: DEPTH_32BPP, image_width: 13'd1, image_height: 13'd1,
                     bottom_up: 1'b1, keep_alpha: 1'b0};
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_DEPTH_MODE:   cfg_ff.depth_mode   <= csr_wdata[2:0];
            CSR_IMAGE_WIDTH:  cfg_ff.image_width  <= csr_wdata;
            CSR_IMAGE_HEIGHT: cfg_ff.image_height <= csr_wdata;
            CSR_BOTTOM_UP:    cfg_ff.bottom_up    <= csr_wdata[0];
            CSR_KEEP_ALPHA:   cfg_ff.keep_alpha   <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   bmp_pd_sequencer #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_sequencer (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .restart   (restart),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .pix_valid (pix_valid),
      .pix       (pix),
      .pix_ready (pix_ready),
      .pal_wr    (pal_wr)
   );

   bmp_pd_lookup #(
      .PALETTE_DEPTH (PALETTE_DEPTH)
   ) u_lookup (
      .clock     (clock),
      .reset     (reset),
      .pal_wr    (pal_wr),
      .pix_valid (pix_valid),
      .pix       (pix),
      .pix_ready (pix_ready),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
